### hdl/msta_pkg.sv
`timescale 1ns / 1ps

package msta_pkg;

   // Default slot count of the table
   localparam int unsigned ALARM_SLOTS_DEF = 8;

   // Field widths of one command and one response beat
   localparam int unsigned CMD_W    = 2;
   localparam int unsigned TICK_W   = 8;
   localparam int unsigned INDEX_W  = 3;
   localparam int unsigned MASK_W   = 8;

   // Command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_SET   = 2'd0,
      CMD_CHG   = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   // Response status codes
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   // One command beat
   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [TICK_W-1:0]  delay;
      logic               periodic;
      logic [INDEX_W-1:0] alarm_index;
   } req_type;

   // One response beat
   typedef struct packed {
      logic               status;
      logic [INDEX_W-1:0] granted_slot;
      logic [MASK_W-1:0]  fired_mask;
   } rsp_type;

endpackage

### hdl/msta_ifc.sv
`timescale 1ns / 1ps

// Command channel
interface msta_req_ifc;
   logic                            valid;
   logic                            ready;
   logic [msta_pkg::CMD_W-1:0]      cmd;
   logic [msta_pkg::TICK_W-1:0]     delay;
   logic                            periodic;
   logic [msta_pkg::INDEX_W-1:0]    alarm_index;

   modport source (output valid, cmd, delay, periodic, alarm_index, input ready);
   modport sink   (input valid, cmd, delay, periodic, alarm_index, output ready);
endinterface

// Response channel
interface msta_rsp_ifc;
   logic                            valid;
   logic                            ready;
   logic                            status;
   logic [msta_pkg::INDEX_W-1:0]    granted_slot;
   logic [msta_pkg::MASK_W-1:0]     fired_mask;

   modport source (output valid, status, granted_slot, fired_mask, input ready);
   modport sink   (input valid, status, granted_slot, fired_mask, output ready);
endinterface

### hdl/msta_slots.sv
`timescale 1ns / 1ps

module msta_slots #(
   parameter int unsigned ALARM_SLOTS = msta_pkg::ALARM_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_accept,
   input  msta_pkg::req_type cmd_beat,
   output msta_pkg::rsp_type rsp_beat
);
   import msta_pkg::*;

   localparam int unsigned CNT_W = $clog2(ALARM_SLOTS + 1);

   // Slot state
   logic [TICK_W-1:0]      remain_ff [ALARM_SLOTS];
   logic [TICK_W-1:0]      remain_in [ALARM_SLOTS];
   logic [TICK_W-1:0]      period_ff [ALARM_SLOTS];
   logic [TICK_W-1:0]      period_in [ALARM_SLOTS];
   logic [ALARM_SLOTS-1:0] enabled_ff;
   logic [ALARM_SLOTS-1:0] enabled_in;
   logic [ALARM_SLOTS-1:0] periodic_ff;
   logic [ALARM_SLOTS-1:0] periodic_in;

   logic [ALARM_SLOTS-1:0] free_slots;
   logic [ALARM_SLOTS-1:0] grant_onehot;
   logic [INDEX_W-1:0]     grant_num;
   logic                   set_ok;
   logic [TICK_W-1:0]      dec_val;

   // Lowest free slot as a one-hot vector, then its number
   assign free_slots   = ~enabled_ff;
   assign grant_onehot = free_slots & (~free_slots + ALARM_SLOTS'(1));
   assign set_ok       = (cmd_beat.cmd == CMD_SET) && (cmd_beat.delay != '0) &&
                         (free_slots != '0);

   always_comb begin
      grant_num = '0;
      for (int k = 0; k < ALARM_SLOTS; k++) begin
         if (grant_onehot[k]) begin
            grant_num = grant_num | INDEX_W'(k);
         end
      end
   end

   // Next slot state and response, one lane per slot
   always_comb begin
      dec_val              = '0;
      rsp_beat.status      = STATUS_OK;
      rsp_beat.granted_slot = '0;
      rsp_beat.fired_mask  = '0;
      enabled_in           = enabled_ff;
      periodic_in          = periodic_ff;
      for (int k = 0; k < ALARM_SLOTS; k++) begin
         remain_in[k] = remain_ff[k];
         period_in[k] = period_ff[k];
      end
      case (cmd_beat.cmd)
         CMD_SET: begin
            if (set_ok) begin
               rsp_beat.granted_slot = grant_num;
               for (int k = 0; k < ALARM_SLOTS; k++) begin
                  if (grant_onehot[k]) begin
                     remain_in[k]   = cmd_beat.delay;
                     periodic_in[k] = cmd_beat.periodic;
                     enabled_in[k]  = 1'b1;
                     if (cmd_beat.periodic) begin
                        period_in[k] = cmd_beat.delay;
                     end
                  end
               end
            end else begin
               rsp_beat.status = STATUS_REJECT;
            end
         end
         CMD_CHG: begin
            for (int k = 0; k < ALARM_SLOTS; k++) begin
               if (k < 8 && cmd_beat.alarm_index == INDEX_W'(k)) begin
                  remain_in[k] = cmd_beat.delay;
                  period_in[k] = cmd_beat.delay;
               end
            end
         end
         CMD_TICK: begin
            for (int k = 0; k < ALARM_SLOTS; k++) begin
               dec_val = remain_ff[k] - TICK_W'(1);
               if (enabled_ff[k]) begin
                  remain_in[k] = dec_val;
                  if (dec_val == '0) begin
                     if (k < MASK_W) begin
                        rsp_beat.fired_mask[k % MASK_W] = 1'b1;
                     end
                     if (periodic_ff[k]) begin
                        remain_in[k] = period_ff[k];
                     end else begin
                        enabled_in[k] = 1'b0;
                     end
                  end
               end
            end
         end
         default: begin
            // no-op command: hold everything
         end
      endcase
   end

   // Commit slot state on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff  <= '0;
         periodic_ff <= '0;
         for (int k = 0; k < ALARM_SLOTS; k++) begin
            remain_ff[k] <= '0;
            period_ff[k] <= '0;
         end
      end else if (cmd_accept) begin
         enabled_ff  <= enabled_in;
         periodic_ff <= periodic_in;
         for (int k = 0; k < ALARM_SLOTS; k++) begin
            remain_ff[k] <= remain_in[k];
            period_ff[k] <= period_in[k];
         end
      end
   end

   // A granted set enables exactly one more slot
   a_set_grows: assert property (@(posedge clock) disable iff (reset)
      cmd_accept && set_ok |=>
         CNT_W'($countones(enabled_ff)) == CNT_W'($countones($past(enabled_ff)) + 1))
      else $error("granted set did not enable exactly one slot");

   // A tick never enables a slot
   a_tick_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd_accept && cmd_beat.cmd == CMD_TICK |=>
         (enabled_ff & ~$past(enabled_ff)) == '0)
      else $error("tick enabled a slot");

   // Change delay leaves the enable and periodic flags alone
   a_chg_flags: assert property (@(posedge clock) disable iff (reset)
      cmd_accept && cmd_beat.cmd == CMD_CHG |=>
         $stable(enabled_ff) && $stable(periodic_ff))
      else $error("change delay touched slot flags");

endmodule

### hdl/multi_slot_tick_alarm_table_unit.sv
`timescale 1ns / 1ps
// Each accepted command's response is registered in the output or the skid stage.
// One command per cycle unless skid is full; update and allocation are combinational.
// An output register plus a skid stage let a command enter while a response waits.
// Reset (synchronous, active high) frees all slots and clears counts and periods.

module multi_slot_tick_alarm_table_unit #(
   parameter int unsigned ALARM_SLOTS = msta_pkg::ALARM_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   msta_req_ifc.sink   req_bus,
   msta_rsp_ifc.source rsp_bus
);
   import msta_pkg::*;

   req_type cmd_beat;
   rsp_type rsp_beat;
   logic    cmd_accept;

   rsp_type out_ff;
   rsp_type out_in;
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type skid_ff;
   rsp_type skid_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;

   // Gather the command beat
   assign cmd_beat.cmd         = req_bus.cmd;
   assign cmd_beat.delay       = req_bus.delay;
   assign cmd_beat.periodic    = req_bus.periodic;
   assign cmd_beat.alarm_index = req_bus.alarm_index;

   assign req_bus.ready = ~skid_valid_ff;
   assign cmd_accept    = req_bus.valid & req_bus.ready;

   msta_slots #(
      .ALARM_SLOTS (ALARM_SLOTS)
   ) u_slots (
      .clock      (clock),
      .reset      (reset),
      .cmd_accept (cmd_accept),
      .cmd_beat   (cmd_beat),
      .rsp_beat   (rsp_beat)
   );

   // Route the response into the output register or the skid stage
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_bus.ready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = rsp_beat;
            out_valid_in = cmd_accept;
         end
      end else if (cmd_accept) begin
         skid_in       = rsp_beat;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // Drive the response channel
   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.status       = out_ff.status;
   assign rsp_bus.granted_slot = out_ff.granted_slot;
   assign rsp_bus.fired_mask   = out_ff.fired_mask;

   // The skid stage only fills behind a waiting output beat
   a_skid_behind: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a beat with the output register empty");

   // A held skid beat drains into the output register once the sink takes a beat
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_bus.ready |=> !skid_valid_ff && out_valid_ff)
      else $error("skid beat did not drain");

   // A rejected set carries no slot number and no fired slots
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.status == STATUS_REJECT |->
         out_ff.granted_slot == '0 && out_ff.fired_mask == '0)
      else $error("rejected set carries slot or fire bits");

endmodule
